### hw/rtl/dnd_pkg.sv
package dnd_pkg;

    localparam int MSG_DEPTH = 512;
    localparam int NAME_CAP  = 256;
    localparam int MAX_LABEL = 63;
    localparam int MAX_NAME  = 255;

    localparam logic [5:0] JUMP_LIMIT_RESET = 6'd32;
    localparam logic [7:0] PTR_MASK  = 8'hC0;
    localparam logic [7:0] LOW6_MASK = 8'h3F;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;       // latch start, length, clear walk state
        logic rd_cursor;   // issue store read at cursor
        logic rd_next;     // issue store read at cursor + 1
        logic lab_latch;   // capture label byte
        logic ptr_take;    // apply pointer: jump, count
        logic dot_write;   // write '.' into name store
        logic chr_write;   // write data byte into name store, advance cursor
        logic lab_skip;    // advance cursor past label byte
        logic term;        // record resume offset at terminator
        logic out_start;   // reset group counter
        logic grp_rd;      // issue name store read
        logic grp_pack;    // pack returned char into group
        logic grp_next;    // advance to next group
    } dnd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cur_oob;     // cursor >= length
        logic nxt_oob;     // cursor + 1 >= length
        logic lab_zero;
        logic lab_ptr;
        logic lab_bad;     // reserved type, too long, past length, name limit
        logic ptr_bad;     // jump limit or forward target
        logic lab_done;    // all label bytes copied
        logic need_dot;
        logic grp_full;    // group complete (8 chars or end of name)
        logic grp_last;
    } dnd_sts_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

### hw/rtl/dnd_ram.sv
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/dnd_ctrl.sv
module dnd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dec_valid,  // decode word offered
    output logic              dec_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_err,
    output dnd_pkg::dnd_cmd_t cmd,
    input  dnd_pkg::dnd_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDLAB, ST_LAB, ST_RDPTR, ST_PTR, ST_DOT, ST_CHR,
        ST_GRD, ST_GPACK, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   err_reg, err_next;

    assign dec_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_err   = err_reg;

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (dec_valid)
                begin
                    cmd.start  = 1'b1;
                    err_next   = 1'b0;
                    state_next = ST_RDLAB;
                end
            end
            ST_RDLAB:
            begin
                if (sts.cur_oob)
                begin
                    err_next   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.rd_cursor = 1'b1;
                    state_next    = ST_LAB;
                end
            end
            ST_LAB:
            begin
                cmd.lab_latch = 1'b1;
                if (sts.lab_zero)
                begin
                    cmd.term      = 1'b1;
                    cmd.out_start = 1'b1;
                    state_next    = ST_GRD;
                end
                else if (sts.lab_ptr)
                begin
                    if (sts.nxt_oob)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_RDPTR;
                    end
                end
                else if (sts.lab_bad)
                begin
                    err_next   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.lab_skip = 1'b1;
                    state_next   = sts.need_dot ? ST_DOT : ST_CHR;
                end
            end
            ST_RDPTR:
            begin
                // keep the second pointer byte on the read port
                cmd.rd_next = 1'b1;
                state_next  = ST_PTR;
            end
            ST_PTR:
            begin
                if (sts.ptr_bad)
                begin
                    err_next   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.ptr_take = 1'b1;
                    state_next   = ST_RDLAB;
                end
            end
            ST_DOT:
            begin
                cmd.dot_write = 1'b1;
                state_next    = ST_CHR;
            end
            ST_CHR:
            begin
                // one read in flight per cycle; each write comes in the cycle after its read
                cmd.chr_write = 1'b1;
                if (sts.lab_done)
                begin
                    state_next = ST_RDLAB;
                end
            end
            ST_GRD:
            begin
                if (sts.grp_full)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.grp_rd = 1'b1;
                    state_next = ST_GPACK;
                end
            end
            ST_GPACK:
            begin
                cmd.grp_pack = 1'b1;
                state_next   = ST_GRD;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (err_reg || sts.grp_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.grp_next = 1'b1;
                        state_next   = ST_GRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

endmodule

### hw/rtl/dnd_dpath.sv
module dnd_dpath #(
    parameter int MSG_DEPTH = dnd_pkg::MSG_DEPTH,
    parameter int NAME_CAP  = dnd_pkg::NAME_CAP,
    parameter int MAX_LABEL = dnd_pkg::MAX_LABEL,
    parameter int MAX_NAME  = dnd_pkg::MAX_NAME
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_we,
    input  logic [8:0]        load_pos,
    input  logic [7:0]        load_byte,
    input  logic [9:0]        dec_len,
    input  logic [5:0]        jump_limit,
    input  logic              out_err,
    input  dnd_pkg::dnd_cmd_t cmd,
    output dnd_pkg::dnd_sts_t sts,
    output logic [63:0]       name_chars,
    output logic [3:0]        char_count,
    output logic [9:0]        next_offset
);

    localparam int MAW = $clog2(MSG_DEPTH);
    localparam int NAW = $clog2(NAME_CAP);
    localparam int CW  = MAW + 2;     // cursor width, holds past-end sums
    localparam int LW  = NAW + 1;     // name length width

    logic [CW-1:0]  cur_reg, len_reg, resume_reg;
    logic           ptaken_reg;
    logic [6:0]     jumps_reg;
    logic [LW-1:0]  nlen_reg, grp_reg, gidx_reg;
    logic [7:0]     lab_reg;
    logic [5:0]     rem_reg;         // label bytes left to read
    logic [6:0]     wleft_reg;       // label bytes left to write
    logic [7:0]     gch_reg [8];
    logic [3:0]     gcnt_reg;

    logic [7:0]     msg_rd, name_rd;
    logic [MAW-1:0] msg_raddr;
    logic           msg_we;
    logic [MAW-1:0] msg_waddr;

    // ---- message store ----
    assign msg_we    = load_we && ({1'b0, load_pos} < 10'(MSG_DEPTH));
    assign msg_waddr = MAW'(load_pos);

    always_comb
    begin
        msg_raddr = cur_reg[MAW-1:0];
        if (cmd.rd_next)
        begin
            msg_raddr = MAW'(cur_reg + CW'(1));
        end
    end

    dnd_ram #(.WIDTH(8), .DEPTH(MSG_DEPTH)) u_msg (
        .clk   (clk),
        .we    (msg_we),
        .waddr (msg_waddr),
        .wdata (load_byte),
        .raddr (msg_raddr),
        .rdata (msg_rd)
    );

    // ---- name store ----
    logic           nm_we;
    logic [NAW-1:0] nm_waddr;
    logic [7:0]     nm_wdata;
    logic           wr_chr;

    // a char write is due once its read data has returned
    assign wr_chr   = cmd.chr_write && (wleft_reg != 7'd0) &&
                      (7'(rem_reg) != wleft_reg);
    assign nm_we    = cmd.dot_write || wr_chr;
    assign nm_waddr = nlen_reg[NAW-1:0];
    assign nm_wdata = cmd.dot_write ? dnd_pkg::DOT_CHAR : dnd_pkg::to_lower(msg_rd);

    dnd_ram #(.WIDTH(8), .DEPTH(NAME_CAP)) u_name (
        .clk   (clk),
        .we    (nm_we),
        .waddr (nm_waddr),
        .wdata (nm_wdata),
        .raddr (NAW'(grp_reg + gidx_reg)),
        .rdata (name_rd)
    );

    // ---- label checks ----
    logic [7:0]    lab;
    logic [CW-1:0] lab_end;
    logic [LW+1:0] cap_need, name_need;
    logic [13:0]   target;

    assign lab       = msg_rd;
    assign lab_end   = cur_reg + CW'(1) + CW'(lab);
    assign cap_need  = (LW+2)'(nlen_reg) + ((nlen_reg != '0) ? (LW+2)'(1) : '0)
                       + (LW+2)'(lab) + (LW+2)'(1);
    assign name_need = (LW+2)'(nlen_reg) + (LW+2)'(lab);
    assign target    = {lab_reg[5:0], msg_rd};

    assign sts.cur_oob  = (cur_reg >= len_reg);
    assign sts.nxt_oob  = (cur_reg + CW'(1) >= len_reg);
    assign sts.lab_zero = (lab == 8'h00);
    assign sts.lab_ptr  = ((lab & dnd_pkg::PTR_MASK) == dnd_pkg::PTR_MASK);
    assign sts.lab_bad  = ((lab & dnd_pkg::PTR_MASK) != 8'h00)
                       || (lab > 8'(MAX_LABEL))
                       || (lab_end > len_reg)
                       || (cap_need > (LW+2)'(NAME_CAP))
                       || (name_need > (LW+2)'(MAX_NAME));
    assign sts.ptr_bad  = ((jumps_reg + 7'd1) > {1'b0, jump_limit})
                       || ({2'b0, target} >= 16'(cur_reg));
    assign sts.lab_done = (wleft_reg == 7'd0)
                       || ((wleft_reg == 7'd1) && (rem_reg == 6'd0));
    assign sts.need_dot = (nlen_reg != '0);
    assign sts.grp_full = (gidx_reg == LW'(8)) || (grp_reg + gidx_reg >= nlen_reg);
    assign sts.grp_last = (grp_reg + LW'(8) >= nlen_reg);

    // ---- output group ----
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            name_chars[8*k +: 8] = (!out_err && (4'(k) < gcnt_reg)) ? gch_reg[k] : 8'h00;
        end
        char_count  = out_err ? 4'd0 : gcnt_reg;
        next_offset = (!out_err && sts.grp_last) ? 10'(resume_reg) : 10'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            len_reg    <= '0;
            resume_reg <= '0;
            ptaken_reg <= 1'b0;
            jumps_reg  <= '0;
            nlen_reg   <= '0;
            grp_reg    <= '0;
            gidx_reg   <= '0;
            lab_reg    <= '0;
            rem_reg    <= '0;
            wleft_reg  <= '0;
            gcnt_reg   <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                cur_reg    <= CW'(load_pos);
                len_reg    <= (dec_len > 10'(MSG_DEPTH)) ? CW'(MSG_DEPTH) : CW'(dec_len);
                resume_reg <= '0;
                ptaken_reg <= 1'b0;
                jumps_reg  <= '0;
                nlen_reg   <= '0;
            end
            if (cmd.lab_latch)
            begin
                lab_reg <= lab;
            end
            if (cmd.term && !ptaken_reg)
            begin
                resume_reg <= cur_reg + CW'(1);
            end
            if (cmd.ptr_take)
            begin
                jumps_reg <= jumps_reg + 7'd1;
                cur_reg   <= CW'(target);
                if (!ptaken_reg)
                begin
                    resume_reg <= cur_reg + CW'(2);
                    ptaken_reg <= 1'b1;
                end
            end
            if (cmd.lab_skip)
            begin
                cur_reg   <= cur_reg + CW'(1);
                rem_reg   <= lab[5:0];
                wleft_reg <= 7'(lab[5:0]);
            end
            if (cmd.dot_write)
            begin
                nlen_reg <= nlen_reg + LW'(1);
            end
            if (cmd.chr_write)
            begin
                // read side: the RAM address is the cursor
                if (rem_reg != 6'd0)
                begin
                    rem_reg <= rem_reg - 6'd1;
                    cur_reg <= cur_reg + CW'(1);
                end
                if (wr_chr)
                begin
                    wleft_reg <= wleft_reg - 7'd1;
                    nlen_reg  <= nlen_reg + LW'(1);
                end
            end
            if (cmd.out_start)
            begin
                grp_reg  <= '0;
                gidx_reg <= '0;
                gcnt_reg <= '0;
            end
            if (cmd.grp_next)
            begin
                grp_reg  <= grp_reg + LW'(8);
                gidx_reg <= '0;
                gcnt_reg <= '0;
            end
            if (cmd.grp_pack)
            begin
                gch_reg[gidx_reg[2:0]] <= name_rd;
                gidx_reg <= gidx_reg + LW'(1);
                gcnt_reg <= gcnt_reg + 4'd1;
            end
        end
    end

endmodule

### hw/rtl/dns_name_decompressor.sv
// DNS name decompressor.
// Input stream s_axis: each word is a load (store one message byte at
// position) or a decode (walk the name at position within msg_len bytes).
// A load gives nothing. A decode is accepted, then walks the stored
// message: it reads each label byte, writes the joining dot, copies the
// characters, follows each pointer hop and stops at the terminating
// zero. Groups are then built from the name buffer one character at a
// time, and each complete group is shown on m_axis.
// Output stream m_axis: groups of up to eight lowercase characters; the
// word with tlast carries the offset after the name. An error gives one
// word with status 1 and tlast.
// Only one decode is in flight; s_axis_tready is low from decode accept
// until the last group is taken. A stalled m_axis holds the word.
// jump_limit is written through cfg_we/cfg_data; the user must write it while idle, the block does not enforce this.
// Reset clears control state and sets jump_limit to 32; the message
// store content is undefined until loaded.
module dns_name_decompressor #(
    parameter int MSG_DEPTH = dnd_pkg::MSG_DEPTH,
    parameter int NAME_CAP  = dnd_pkg::NAME_CAP,
    parameter int MAX_LABEL = dnd_pkg::MAX_LABEL,
    parameter int MAX_NAME  = dnd_pkg::MAX_NAME
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,        // [5:0] jump_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // byte_value[7:0], position[16:8], msg_len[26:17]
    input  logic        s_axis_tuser,    // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,    // name_chars[63:0], char_count[67:64], next_offset[77:68]
    output logic        m_axis_tuser,    // status
    output logic        m_axis_tlast     // last_group
);

    logic [5:0] jlim_reg;
    logic       dec_ready, out_err;
    logic [63:0] chars;
    logic [3:0]  cnt;
    logic [9:0]  noff;
    logic        is_load, is_dec;
    dnd_pkg::dnd_cmd_t cmd;
    dnd_pkg::dnd_sts_t sts;

    assign is_load = s_axis_tvalid && (s_axis_tuser == dnd_pkg::CMD_LOAD) && dec_ready;
    assign is_dec  = s_axis_tvalid && (s_axis_tuser == dnd_pkg::CMD_DECODE);
    assign s_axis_tready = dec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jlim_reg <= dnd_pkg::JUMP_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            jlim_reg <= cfg_data[5:0];
        end
    end

    dnd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (is_dec),
        .dec_ready (dec_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_err   (out_err),
        .cmd       (cmd),
        .sts       (sts)
    );

    dnd_dpath #(
        .MSG_DEPTH (MSG_DEPTH),
        .NAME_CAP  (NAME_CAP),
        .MAX_LABEL (MAX_LABEL),
        .MAX_NAME  (MAX_NAME)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_we     (is_load),
        .load_pos    (s_axis_tdata[16:8]),
        .load_byte   (s_axis_tdata[7:0]),
        .dec_len     (s_axis_tdata[26:17]),
        .jump_limit  (jlim_reg),
        .out_err     (out_err),
        .cmd         (cmd),
        .sts         (sts),
        .name_chars  (chars),
        .char_count  (cnt),
        .next_offset (noff)
    );

    assign m_axis_tdata = {2'b00, noff, cnt, chars};
    assign m_axis_tuser = out_err;
    assign m_axis_tlast = out_err || sts.grp_last;

endmodule
